// ===== hw/rtl/sdr_pkg.sv =====
package sdr_pkg;

	localparam int VAL_W     = 32;
	localparam int FACT_W    = 17;
	localparam int STEP_W    = 31;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;
	localparam int NVAL      = 7;
	localparam int IDX_W     = 3;
	localparam int DIV_CNT_W = 6;
	localparam int MAX_DASHES_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DASH_FACTOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALARS_EN  = 2'd2;

	localparam logic [FACT_W-1:0] FACTOR_ONE      = 17'd65536;
	localparam logic [FACT_W-1:0] DASH_FACTOR_RST = 17'd49152;
	localparam logic [STEP_W-1:0] STEP_RST        = 31'd65536;

	localparam logic [DIV_CNT_W-1:0] ITERS_COUNT = 6'd32;
	localparam logic [DIV_CNT_W-1:0] ITERS_FRAC  = 6'd16;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic                 start;
		logic [VAL_W-1:0]     rem_init;
		logic [VAL_W-1:0]     dividend;
		logic [VAL_W-1:0]     divisor;
		logic [DIV_CNT_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quo;
		logic [VAL_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic              vld;
		logic [IDX_W-1:0]  tag;
		val_t              a;
		val_t              b;
		logic [FACT_W-1:0] m;
	} lerp_req_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] tag;
		val_t             val;
	} lerp_rsp_t;

endpackage

// ===== hw/rtl/streamline_dash_resampler.sv =====
// Dashed streamline resampler. Points enter one request at a time; a first point of a line
// or a point with no dash in its segment is taken without leaving idle. A point with n dashes
// runs the dash count division, then per emitted dash the fraction division, the 14
// interpolations on the one shared multiplier and two output transfers; a point that drops
// dashes adds one silent dash. The divider and the multiplier are single shared units.
// in_ready is low while a point is being worked on. Results come in pairs, dash point then
// end point.
module streamline_dash_resampler
	import sdr_pkg::*;
#(
	parameter int MAX_DASHES_PER_POINT = MAX_DASHES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 first_of_line,
	input  val_t                 point_time,
	input  val_t                 pos_x,
	input  val_t                 pos_y,
	input  val_t                 pos_z,
	input  val_t                 vel_x,
	input  val_t                 vel_y,
	input  val_t                 vel_z,
	input  val_t                 point_scalar,
	input  logic                 inside_cell,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 endpoint,
	output val_t                 out_x,
	output val_t                 out_y,
	output val_t                 out_z,
	output val_t                 out_vx,
	output val_t                 out_vy,
	output val_t                 out_vz,
	output val_t                 out_scalar,
	output logic                 dashes_dropped,
	output logic                 last
);

	localparam int KW = $clog2(MAX_DASHES_PER_POINT + 1);
	localparam logic [VAL_W:0] MAX_N = (VAL_W+1)'(MAX_DASHES_PER_POINT);
	localparam logic signed [VAL_W+1:0] MAXV = (VAL_W+2)'(2147483647);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_DIV_N   = 8'b0000_0010,
		S_DIV_R   = 8'b0000_0100,
		S_MUL_PT  = 8'b0000_1000,
		S_MUL_END = 8'b0001_0000,
		S_OUT_PT  = 8'b0010_0000,
		S_OUT_END = 8'b0100_0000,
		S_FINISH  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [FACT_W-1:0] factor_q;
	logic [STEP_W-1:0] step_q;
	logic              scal_en_q;

	val_t prev_q [NVAL];
	val_t cur_q  [NVAL];
	val_t anc_q  [NVAL];
	val_t pt_q   [NVAL];
	val_t end_q  [NVAL];
	val_t in_vals[NVAL];

	val_t prev_time_q, cur_time_q, dash_time_q, td_q;
	logic line_open_q, line_stopped_q;
	logic [VAL_W-1:0] pad_q;
	logic [15:0]      r_q;
	logic [KW-1:0]    k_q, emit_q;
	logic             dropped_q, silent_q, dstart_q;
	logic [IDX_W-1:0] iss_q;

	div_req_t  dreq;
	div_rsp_t  drsp;
	lerp_req_t lreq;
	lerp_rsp_t lrsp;

	logic [STEP_W-1:0]        step_eff;
	logic [FACT_W-1:0]        factor_eff;
	logic                     in_acc, out_acc, has_dash;
	logic [VAL_W:0]           n_cnt;
	logic signed [VAL_W+1:0]  next_dash, td_last;

	assign step_eff   = (step_q == '0) ? STEP_W'(1) : step_q;
	assign factor_eff = (factor_q > FACTOR_ONE) ? FACTOR_ONE : factor_q;

	assign in_vals[0] = pos_x;
	assign in_vals[1] = pos_y;
	assign in_vals[2] = pos_z;
	assign in_vals[3] = vel_x;
	assign in_vals[4] = vel_y;
	assign in_vals[5] = vel_z;
	assign in_vals[6] = point_scalar;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT_PT) || (state_q == S_OUT_END);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign has_dash  = (dash_time_q >= prev_time_q) && (dash_time_q < point_time);

	assign n_cnt     = {1'b0, drsp.quo} + (VAL_W+1)'(drsp.rem != '0);
	assign next_dash = (VAL_W+2)'(cur_time_q) + (VAL_W+2)'(pad_q);
	assign td_last   = next_dash - (VAL_W+2)'(step_eff);

	// divider requests: dash count first, then one fraction per dash
	always_comb begin
		dreq = '0;
		dreq.start = !dstart_q && ((state_q == S_DIV_N) || (state_q == S_DIV_R));
		if (state_q == S_DIV_N) begin
			dreq.rem_init = '0;
			dreq.dividend = VAL_W'(cur_time_q - dash_time_q);
			dreq.divisor  = VAL_W'(step_eff);
			dreq.iters    = ITERS_COUNT;
		end else begin
			dreq.rem_init = VAL_W'(td_q - prev_time_q);
			dreq.dividend = '0;
			dreq.divisor  = VAL_W'(cur_time_q - prev_time_q);
			dreq.iters    = ITERS_FRAC;
		end
	end

	always_comb begin
		lreq     = '0;
		lreq.tag = iss_q;
		if (state_q == S_MUL_PT) begin
			lreq.vld = (iss_q != IDX_W'(NVAL));
			lreq.a   = prev_q[iss_q];
			lreq.b   = cur_q[iss_q];
			lreq.m   = {1'b0, r_q};
		end else if (state_q == S_MUL_END) begin
			lreq.vld = (iss_q != IDX_W'(NVAL));
			lreq.a   = anc_q[iss_q];
			lreq.b   = pt_q[iss_q];
			lreq.m   = factor_eff;
		end
	end

	sdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	sdr_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lreq),
		.rsp    (lrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q  <= DASH_FACTOR_RST;
			step_q    <= STEP_RST;
			scal_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DASH_FACTOR: factor_q  <= cfg_data[FACT_W-1:0];
				REG_STEP_LENGTH: step_q    <= cfg_data[STEP_W-1:0];
				REG_SCALARS_EN:  scal_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			line_open_q    <= 1'b0;
			line_stopped_q <= 1'b0;
			prev_time_q    <= '0;
			dash_time_q    <= '0;
			dstart_q       <= 1'b0;
			iss_q          <= '0;
			k_q            <= '0;
			emit_q         <= '0;
			dropped_q      <= 1'b0;
			silent_q       <= 1'b0;
			for (int i = 0; i < NVAL; i++) begin
				prev_q[i] <= '0;
				anc_q[i]  <= '0;
			end
		end else begin
			if (dreq.start)
				dstart_q <= 1'b1;
			if (drsp.done)
				dstart_q <= 1'b0;
			if (lreq.vld)
				iss_q <= iss_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (first_of_line) begin
							for (int i = 0; i < NVAL; i++) begin
								prev_q[i] <= in_vals[i];
								anc_q[i]  <= in_vals[i];
							end
							prev_time_q    <= point_time;
							dash_time_q    <= point_time;
							line_open_q    <= 1'b1;
							line_stopped_q <= 1'b0;
						end else if (line_open_q && !line_stopped_q) begin
							if (!inside_cell) begin
								line_stopped_q <= 1'b1;
							end else if (has_dash) begin
								state_q <= S_DIV_N;
							end else begin
								for (int i = 0; i < NVAL; i++)
									prev_q[i] <= in_vals[i];
								prev_time_q <= point_time;
							end
						end
					end
				end
				S_DIV_N: begin
					if (drsp.done) begin
						dropped_q <= n_cnt > MAX_N;
						emit_q    <= (n_cnt > MAX_N) ? KW'(MAX_DASHES_PER_POINT) : n_cnt[KW-1:0];
						pad_q     <= (drsp.rem == '0) ? '0 : VAL_W'(step_eff) - drsp.rem;
						td_q      <= dash_time_q;
						k_q       <= '0;
						silent_q  <= 1'b0;
						state_q   <= S_DIV_R;
					end
				end
				S_DIV_R: begin
					if (drsp.done) begin
						r_q     <= drsp.quo[15:0];
						iss_q   <= '0;
						state_q <= S_MUL_PT;
					end
				end
				S_MUL_PT: begin
					if (lrsp.vld && lrsp.tag == IDX_W'(NVAL - 1)) begin
						iss_q <= '0;
						if (silent_q) begin
							for (int i = 0; i < NVAL - 1; i++)
								anc_q[i] <= pt_q[i];
							anc_q[NVAL-1] <= lrsp.val;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_MUL_END;
						end
					end
				end
				S_MUL_END: begin
					if (lrsp.vld && lrsp.tag == IDX_W'(NVAL - 1))
						state_q <= S_OUT_PT;
				end
				S_OUT_PT: begin
					if (out_acc)
						state_q <= S_OUT_END;
				end
				S_OUT_END: begin
					if (out_acc) begin
						for (int i = 0; i < NVAL; i++)
							anc_q[i] <= pt_q[i];
						k_q  <= k_q + 1'b1;
						if (KW'(k_q + 1'b1) != emit_q) begin
							td_q    <= VAL_W'(td_q + $signed({1'b0, step_eff}));
							state_q <= S_DIV_R;
						end else if (dropped_q) begin
							// last dropped dash still moves the anchor
							td_q     <= VAL_W'(td_last);
							silent_q <= 1'b1;
							state_q  <= S_DIV_R;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					dash_time_q <= (next_dash > MAXV) ? VAL_W'(MAXV) : VAL_W'(next_dash);
					for (int i = 0; i < NVAL; i++)
						prev_q[i] <= cur_q[i];
					prev_time_q <= cur_time_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < NVAL; i++)
				cur_q[i] <= in_vals[i];
			cur_time_q <= point_time;
		end
		if (lrsp.vld && state_q == S_MUL_PT)
			pt_q[lrsp.tag] <= lrsp.val;
		if (lrsp.vld && state_q == S_MUL_END)
			end_q[lrsp.tag] <= lrsp.val;
	end

	always_comb begin
		endpoint       = (state_q == S_OUT_END);
		out_x          = endpoint ? end_q[0] : pt_q[0];
		out_y          = endpoint ? end_q[1] : pt_q[1];
		out_z          = endpoint ? end_q[2] : pt_q[2];
		out_vx         = endpoint ? end_q[3] : pt_q[3];
		out_vy         = endpoint ? end_q[4] : pt_q[4];
		out_vz         = endpoint ? end_q[5] : pt_q[5];
		out_scalar     = !scal_en_q ? '0 : (endpoint ? end_q[6] : pt_q[6]);
		dashes_dropped = dropped_q;
		last           = endpoint && (KW'(k_q + 1'b1) == emit_q);
	end

	ap_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken while results pending");
	ap_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (k_q < emit_q)) else $error("dash index past emit count");
	ap_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT_PT && out_ready) |=> (state_q == S_OUT_END))
		else $error("dash point not followed by end point");
	ap_silent: assert property (@(posedge clk) disable iff (!arst_n)
		silent_q |-> dropped_q) else $error("silent dash without dropped dashes");

endmodule

// ===== hw/rtl/sdr_div.sv =====
module sdr_div
	import sdr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [VAL_W-1:0]     rem_q, dvd_q, dsr_q, quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [VAL_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, dvd_q[VAL_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				cnt_q <= req.iters;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			// one restoring step per cycle
			rem_q <= fits ? VAL_W'(trial - {1'b0, dsr_q}) : trial[VAL_W-1:0];
			dvd_q <= {dvd_q[VAL_W-2:0], 1'b0};
			quo_q <= {quo_q[VAL_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

	ap_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0)) else $error("divider done while still iterating");
	ap_load: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> (cnt_q == $past(req.iters))) else $error("divider count not loaded");
	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held longer than one cycle");

endmodule

// ===== hw/rtl/sdr_lerp.sv =====
module sdr_lerp
	import sdr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lerp_req_t req,
	output lerp_rsp_t rsp
);

	localparam int PROD_W = VAL_W + FACT_W + 2;

	logic signed [VAL_W:0]    diff;
	logic signed [PROD_W-1:0] prod_s1, rnd;
	val_t                     a_s1, val_s2;
	logic [IDX_W-1:0]         tag_s1, tag_s2;
	logic                     vld_s1, vld_s2;

	assign diff = $signed({req.b[VAL_W-1], req.b}) - $signed({req.a[VAL_W-1], req.a});
	assign rnd  = (prod_s1 + $signed(PROD_W'(32768))) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(diff * $signed({1'b0, req.m}));
		a_s1    <= req.a;
		tag_s1  <= req.tag;
		// round to nearest, halves up
		val_s2  <= VAL_W'(a_s1 + rnd[VAL_W-1:0]);
		tag_s2  <= tag_s1;
	end

	assign rsp.vld = vld_s2;
	assign rsp.tag = tag_s2;
	assign rsp.val = val_s2;

endmodule

// ===== dv/tb.sv =====
module tb;
	import sdr_pkg::*;

	localparam int MAX_DASHES = 16;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 800;

	typedef struct packed {
		logic first;
		val_t t;
		val_t px, py, pz;
		val_t vx, vy, vz;
		val_t sc;
		logic in_cell;
	} point_t;

	typedef struct packed {
		logic endp;
		val_t x, y, z;
		val_t vx, vy, vz;
		val_t sc;
		logic dropped;
		logic last;
	} dash_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic first_of_line = 0;
	val_t point_time = '0, pos_x = '0, pos_y = '0, pos_z = '0;
	val_t vel_x = '0, vel_y = '0, vel_z = '0, point_scalar = '0;
	logic inside_cell = 0;
	logic out_valid;
	logic out_ready = 0;
	logic endpoint, dashes_dropped, last;
	val_t out_x, out_y, out_z, out_vx, out_vy, out_vz, out_scalar;

	streamline_dash_resampler DUT (.*);

	always #1 clk = ~clk;

	point_t pending_points[$];
	dash_t dashes_due[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit calm = 0;

	// dash generator state and registers
	longint factor_reg = 49152, step_reg = 65536;
	bit scalars_on = 0;
	longint prev_t, prev_p[3], prev_v[3], prev_s;
	longint anch_p[3], anch_v[3], anch_s;
	longint next_dash;
	bit line_open = 0, line_stopped = 0;

	initial begin
		prev_t = 0; prev_s = 0; anch_s = 0; next_dash = 0;
		for (int j = 0; j < 3; j++) begin
			prev_p[j] = 0; prev_v[j] = 0; anch_p[j] = 0; anch_v[j] = 0;
		end
	end

	function automatic longint round16(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint blend(longint a, longint b, longint r);
		return a + round16((b - a) * r);
	endfunction

	task automatic resample_point(input point_t pt);
		longint t, cp[3], cv[3], cs, s, f, den, n, emit, k, td, r, nt;
		longint x[3], v[3], xs, xe[3], ve[3], se;
		dash_t d, batch[$];
		bit dropped;
		t = pt.t;
		cp[0] = pt.px; cp[1] = pt.py; cp[2] = pt.pz;
		cv[0] = pt.vx; cv[1] = pt.vy; cv[2] = pt.vz;
		cs = pt.sc;
		if (pt.first) begin
			for (int j = 0; j < 3; j++) begin
				prev_p[j] = cp[j]; prev_v[j] = cv[j]; anch_p[j] = cp[j]; anch_v[j] = cv[j];
			end
			prev_s = cs; anch_s = cs; prev_t = t; next_dash = t;
			line_open = 1; line_stopped = 0;
			return;
		end
		if (!line_open || line_stopped)
			return;
		if (!pt.in_cell) begin
			line_stopped = 1;
			return;
		end
		if (next_dash >= prev_t && next_dash < t) begin
			s = (step_reg == 0) ? 1 : step_reg;
			f = (factor_reg > 65536) ? 65536 : factor_reg;
			den = t - prev_t;
			n = (t - next_dash + s - 1) / s;
			emit = (n > MAX_DASHES) ? MAX_DASHES : n;
			dropped = n > emit;
			// skipped dashes leave no trace except the final one, which moves the anchor
			for (longint i = 0; i < emit + (dropped ? 1 : 0); i++) begin
				k = (i < emit) ? i : n - 1;
				td = next_dash + k * s;
				r = ((td - prev_t) << 16) / den;
				for (int j = 0; j < 3; j++) begin
					x[j] = blend(prev_p[j], cp[j], r);
					v[j] = blend(prev_v[j], cv[j], r);
					xe[j] = anch_p[j] + round16((x[j] - anch_p[j]) * f);
					ve[j] = anch_v[j] + round16((v[j] - anch_v[j]) * f);
				end
				xs = blend(prev_s, cs, r);
				se = anch_s + round16((xs - anch_s) * f);
				if (i < emit) begin
					d = '{1'b0, val_t'(x[0]), val_t'(x[1]), val_t'(x[2]), val_t'(v[0]),
						val_t'(v[1]), val_t'(v[2]), scalars_on ? val_t'(xs) : val_t'(0),
						dropped, 1'b0};
					batch.push_back(d);
					d = '{1'b1, val_t'(xe[0]), val_t'(xe[1]), val_t'(xe[2]), val_t'(ve[0]),
						val_t'(ve[1]), val_t'(ve[2]), scalars_on ? val_t'(se) : val_t'(0),
						dropped, 1'b0};
					batch.push_back(d);
				end
				for (int j = 0; j < 3; j++) begin
					anch_p[j] = x[j]; anch_v[j] = v[j];
				end
				anch_s = xs;
			end
			nt = next_dash + n * s;
			next_dash = (nt > 64'sd2147483647) ? 64'sd2147483647 : nt;
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				dashes_due.push_back(batch[i]);
		end
		for (int j = 0; j < 3; j++) begin
			prev_p[j] = cp[j]; prev_v[j] = cv[j];
		end
		prev_s = cs; prev_t = t;
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 26);
			if (!in_valid || in_ready) begin
				if (pending_points.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
					point_t p;
					p = pending_points.pop_front();
					first_of_line <= p.first;
					point_time <= p.t;
					pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
					vel_x <= p.vx; vel_y <= p.vy; vel_z <= p.vz;
					point_scalar <= p.sc;
					inside_cell <= p.in_cell;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles = quiet_cycles + 1;
			if (out_valid && out_ready) begin
				dash_t got, want;
				quiet_cycles = 0;
				got = '{endpoint, out_x, out_y, out_z, out_vx, out_vy, out_vz, out_scalar,
					dashes_dropped, last};
				if (dashes_due.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = dashes_due.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, got);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				quiet_cycles = 0;
				resample_point('{first_of_line, point_time, pos_x, pos_y, pos_z, vel_x, vel_y,
					vel_z, point_scalar, inside_cell});
			end
			if (quiet_cycles > STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic val_t any_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic point_t make_point(bit first, longint t, bit in_cell);
		point_t p;
		p.first = first; p.t = val_t'(t); p.in_cell = in_cell;
		p.px = any_value(); p.py = any_value(); p.pz = any_value();
		p.vx = any_value(); p.vy = any_value(); p.vz = any_value();
		p.sc = any_value();
		return p;
	endfunction

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		case (idx)
			REG_DASH_FACTOR: factor_reg = value;
			REG_STEP_LENGTH: step_reg = value;
			default: scalars_on = value[0];
		endcase
	endtask

	task automatic wait_drained();
		while (pending_points.size() > 0 || in_valid || dashes_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// well-formed lines with random content, plus some noise
	task automatic queue_lines(input int count);
		longint s, t, d;
		int left;
		left = 0;
		t = 0;
		s = (step_reg == 0) ? 1 : step_reg;
		for (int i = 0; i < count; i++) begin
			if (left == 0) begin
				t = longint'($signed($urandom)) / (longint'(1) << $urandom_range(0, 6));
				pending_points.push_back(make_point(1'b1, t, $urandom_range(0, 1)));
				left = $urandom_range(2, 8);
				continue;
			end
			case ($urandom_range(0, 19))
				0: d = -longint'($urandom_range(0, 65536));
				1: d = s * $urandom_range(17, 40);
				default: d = s * $urandom_range(0, 4) + $urandom_range(0, s - 1);
			endcase
			if (t + d > 64'sd2147483647) begin
				left = 0;
				i--;
				continue;
			end
			t = t + d;
			pending_points.push_back(make_point(1'b0, t, $urandom_range(0, 19) != 0));
			left--;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// corner points under the reset settings
		pending_points.push_back(make_point(1'b0, 65536, 1'b1));
		pending_points.push_back(make_point(1'b1, 0, 1'b0));
		pending_points.push_back(make_point(1'b0, 229376, 1'b1));
		pending_points.push_back(make_point(1'b0, 100000, 1'b1));
		pending_points.push_back(make_point(1'b0, 100000, 1'b1));
		pending_points.push_back(make_point(1'b0, 100000 + 40 * 65536, 1'b1));
		pending_points.push_back(make_point(1'b0, 3000000, 1'b0));
		pending_points.push_back(make_point(1'b0, 4000000, 1'b1));
		pending_points.push_back(make_point(1'b1, 32'h7fff0000, 1'b1));
		pending_points.push_back(make_point(1'b0, 32'h7fffffff, 1'b1));
		pending_points.push_back(make_point(1'b0, 32'h7fffffff, 1'b1));
		pending_points.push_back(make_point(1'b1, -64'sd2147483648, 1'b1));
		pending_points.push_back(make_point(1'b0, 64'sd2147483647, 1'b1));
		pending_points.push_back(make_point(1'b0, -64'sd2147483648, 1'b1));
		queue_lines(80);
		wait_drained();

		set_reg(REG_DASH_FACTOR, 65536);
		set_reg(REG_STEP_LENGTH, 16384);
		set_reg(REG_SCALARS_EN, 1);
		@(posedge clk) cfg_we <= 1'b0;
		queue_lines(100);
		wait_drained();

		set_reg(REG_DASH_FACTOR, 0);
		set_reg(REG_STEP_LENGTH, 2147483647);
		set_reg(REG_SCALARS_EN, 0);
		@(posedge clk) cfg_we <= 1'b0;
		calm = 1;
		queue_lines(90);
		wait_drained();
		calm = 0;

		// step of zero behaves as one, factor above one saturates
		set_reg(REG_DASH_FACTOR, 131071);
		set_reg(REG_STEP_LENGTH, 0);
		set_reg(REG_SCALARS_EN, 1);
		@(posedge clk) cfg_we <= 1'b0;
		queue_lines(100);
		wait_drained();

		set_reg(REG_DASH_FACTOR, $urandom_range(0, 65536));
		set_reg(REG_STEP_LENGTH, $urandom_range(1, 262144));
		set_reg(REG_SCALARS_EN, $urandom_range(0, 1));
		@(posedge clk) cfg_we <= 1'b0;
		queue_lines(100);
		wait_drained();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_div.sv
hw/rtl/sdr_lerp.sv
hw/rtl/streamline_dash_resampler.sv
dv/tb.sv
